[rtl/core/write_burst_lane_packer_unit_defines.svh]
// Assertion macros for the write burst lane packer.
// Included by the top level; the macros expect signals clk and rst in scope.
`ifndef WRITE_BURST_LANE_PACKER_UNIT_DEFINES_SVH
`define WRITE_BURST_LANE_PACKER_UNIT_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define WBLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define WBLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define WBLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/wblp_pkg.sv]
// Constants shared by the write burst lane packer: function codes, digest
// seeds and multipliers, and burst limits. No dependencies.
package wblp_pkg;

  // Function codes carried in the input tuser.
  localparam logic [1:0] FUNC_NEW_DESC = 2'd0;
  localparam logic [1:0] FUNC_HEADER   = 2'd1;
  localparam logic [1:0] FUNC_DATA     = 2'd2;

  // Digest seeds and multipliers.
  localparam logic [63:0] SEED_FIRST  = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] SEED_SECOND = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MUL_FIRST   = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] MUL_SECOND  = 64'hBF58_476D_1CE4_E5B9;
  localparam int unsigned MIX_SHIFT   = 31;

  // Largest burst length in beats.
  localparam logic [4:0] BEAT_LIMIT = 5'd16;

  // Lanes per beat after reset, and the widest bus.
  localparam logic [3:0] BUS_RESET = 4'd8;
  localparam logic [3:0] BUS_MAX   = 4'd8;

endpackage

[rtl/core/write_burst_lane_packer_unit.sv]
// Write burst lane packer: packs burst payload bytes into write beats with
// byte strobes and keeps a two-word running digest.
// Depends on wblp_pkg and write_burst_lane_packer_unit_defines.svh.
//
// Sequencing: one transaction at a time; a descriptor, dropped byte or unused code is taken
// in S_IDLE, a header in S_HDR then S_SKIP or S_FLUSH, a data byte in six shared 32x32
// multiplier passes and a mix add, after S_PRE if a full beat from a narrower width goes out
// first, and the burst's last byte ends in S_TAIL for a partial beat and S_FLUSH for padding.
// A beat is on m_tvalid the cycle after it is sent; a stalled output holds the sequencer.
// Reset is synchronous: clears digest, burst state and output valid, sets bus_bytes to 8.
`include "write_burst_lane_packer_unit_defines.svh"

module write_burst_lane_packer_unit
  import wblp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Configuration write channel (bus_bytes).
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: lead_bytes[6:0], useful_count[14:7], beat_count[19:15],
  // data_byte[27:20], zero fill [31:28].
  input  logic [31:0]  s_tdata,
  // tuser: func[1:0].
  input  logic [1:0]   s_tuser,
  // Output stream, tlast is last_beat.
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: beat_data[63:0], byte_strobe[71:64], digest_first[135:72],
  // digest_second[199:136].
  output logic [199:0] m_tdata,
  output logic         m_tlast
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00_0000_0000_0001,
    S_HDR   = 14'b00_0000_0000_0010,
    S_SKIP  = 14'b00_0000_0000_0100,
    S_PRE   = 14'b00_0000_0000_1000,
    S_H0    = 14'b00_0000_0001_0000,
    S_H1    = 14'b00_0000_0010_0000,
    S_H2    = 14'b00_0000_0100_0000,
    S_H3    = 14'b00_0000_1000_0000,
    S_H4    = 14'b00_0001_0000_0000,
    S_H5    = 14'b00_0010_0000_0000,
    S_H6    = 14'b00_0100_0000_0000,
    S_POST  = 14'b00_1000_0000_0000,
    S_TAIL  = 14'b01_0000_0000_0000,
    S_FLUSH = 14'b10_0000_0000_0000
  } state_t;

  state_t       state;
  logic [3:0]   bus_bytes;
  logic [63:0]  hash_first;
  logic [63:0]  hash_second;
  logic [63:0]  beat_accum;
  logic [7:0]   strobe_accum;
  logic [3:0]   addr_offset;
  logic [7:0]   bytes_remaining;
  logic [4:0]   beats_remaining;

  // Latched input item.
  logic [6:0]   in_lead;
  logic [7:0]   in_useful;
  logic [4:0]   in_beats;
  logic [7:0]   in_data;

  // Header working registers.
  logic [6:0]   lead_rem;
  logic [7:0]   useful_hold;

  // Shared multiplier datapath.
  logic [63:0]  mul_acc;
  logic [63:0]  mix;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  prod;
  logic [63:0]  acc_sum;
  logic [63:0]  first_x;

  // Output register.
  logic         out_valid;
  logic [63:0]  out_beat;
  logic [7:0]   out_strobe;
  logic         out_last;
  logic [63:0]  out_df;
  logic [63:0]  out_ds;

  logic [3:0]   bus;
  logic [4:0]   beats_c;
  logic [7:0]   cap;
  logic [7:0]   lead8;
  logic [7:0]   room;
  logic [7:0]   useful_c;
  logic         s_fire;
  logic         out_free;
  logic         emit_want;
  logic         emit_go;
  logic [4:0]   beats_after;
  logic [3:0]   off_after;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid & s_tready;
  assign m_tvalid  = out_valid;
  assign m_tlast   = out_last;
  assign m_tdata   = {out_ds, out_df, out_strobe, out_beat};
  assign out_free  = !out_valid || m_tready;

  // Effective lane count: zero acts as one, above eight acts as eight.
  always_comb begin
    if (bus_bytes == 4'd0) begin
      bus = 4'd1;
    end else if (bus_bytes > BUS_MAX) begin
      bus = BUS_MAX;
    end else begin
      bus = bus_bytes;
    end
  end

  // Header arithmetic: clamp beats, then cut useful bytes to the burst space.
  always_comb begin
    if (in_beats == 5'd0) begin
      beats_c = 5'd1;
    end else if (in_beats > BEAT_LIMIT) begin
      beats_c = BEAT_LIMIT;
    end else begin
      beats_c = in_beats;
    end
    cap   = 8'({3'b000, beats_c} * {4'b0000, bus});
    lead8 = {1'b0, in_lead};
    room  = cap - lead8;
    if (lead8 >= cap) begin
      useful_c = 8'd0;
    end else if (in_useful > room) begin
      useful_c = room;
    end else begin
      useful_c = in_useful;
    end
  end

  // Operand selection for the shared 32x32 multiplier. Each 64-bit product
  // modulo 2^64 takes three passes: low*low, high*low and low*high.
  assign first_x = hash_first ^ {56'd0, in_data};

  always_comb begin
    case (state)
      S_H0: begin
        mul_a = first_x[31:0];
        mul_b = MUL_FIRST[31:0];
      end
      S_H1: begin
        mul_a = first_x[63:32];
        mul_b = MUL_FIRST[31:0];
      end
      S_H2: begin
        mul_a = first_x[31:0];
        mul_b = MUL_FIRST[63:32];
      end
      S_H4: begin
        mul_a = mix[31:0];
        mul_b = MUL_SECOND[31:0];
      end
      S_H5: begin
        mul_a = mix[63:32];
        mul_b = MUL_SECOND[31:0];
      end
      S_H6: begin
        mul_a = mix[31:0];
        mul_b = MUL_SECOND[63:32];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
  assign acc_sum = mul_acc + {prod[31:0], 32'd0};

  // Which states want to send a beat this cycle.
  always_comb begin
    case (state)
      S_SKIP:  emit_want = (lead_rem >= {3'b000, bus});
      S_PRE:   emit_want = 1'b1;
      S_POST:  emit_want = (addr_offset >= bus);
      S_TAIL:  emit_want = 1'b1;
      S_FLUSH: emit_want = (beats_remaining != 5'd0);
      default: emit_want = 1'b0;
    endcase
  end

  assign emit_go     = emit_want & out_free;
  assign beats_after = beats_remaining - {4'd0, emit_go};
  assign off_after   = emit_go ? 4'd0 : addr_offset;

  // Sequencer, burst state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      bus_bytes       <= BUS_RESET;
      hash_first      <= 64'd0;
      hash_second     <= 64'd0;
      beat_accum      <= 64'd0;
      strobe_accum    <= 8'd0;
      addr_offset     <= 4'd0;
      bytes_remaining <= 8'd0;
      beats_remaining <= 5'd0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bus_bytes <= cfg_data;
      end

      // A new beat loads the output register, a taken one empties it.
      if (emit_go) begin
        out_valid       <= 1'b1;
        out_beat        <= beat_accum;
        out_strobe      <= strobe_accum;
        out_last        <= (beats_remaining == 5'd1);
        out_df          <= hash_first;
        out_ds          <= hash_second;
        beats_remaining <= beats_after;
        beat_accum      <= 64'd0;
        strobe_accum    <= 8'd0;
        addr_offset     <= 4'd0;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_fire) begin
            in_lead   <= s_tdata[6:0];
            in_useful <= s_tdata[14:7];
            in_beats  <= s_tdata[19:15];
            in_data   <= s_tdata[27:20];
            case (s_tuser)
              FUNC_NEW_DESC: begin
                hash_first      <= 64'd0;
                hash_second     <= 64'd0;
                beat_accum      <= 64'd0;
                strobe_accum    <= 8'd0;
                addr_offset     <= 4'd0;
                bytes_remaining <= 8'd0;
                beats_remaining <= 5'd0;
              end
              FUNC_HEADER: begin
                state <= S_HDR;
              end
              FUNC_DATA: begin
                if (bytes_remaining == 8'd0 || beats_remaining == 5'd0) begin
                  bytes_remaining <= 8'd0;
                end else if (addr_offset >= bus) begin
                  state <= S_PRE;
                end else begin
                  state <= S_H0;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // Seed the digest if it is clear, start the burst and choose skip or flush.
        S_HDR: begin
          if (hash_first == 64'd0 && hash_second == 64'd0) begin
            hash_first  <= SEED_FIRST;
            hash_second <= SEED_SECOND;
          end
          beat_accum      <= 64'd0;
          strobe_accum    <= 8'd0;
          addr_offset     <= 4'd0;
          beats_remaining <= beats_c;
          bytes_remaining <= 8'd0;
          lead_rem        <= in_lead;
          useful_hold     <= useful_c;
          if (useful_c == 8'd0) begin
            state <= S_FLUSH;
          end else begin
            state <= S_SKIP;
          end
        end

        // Send the empty beats ahead of the first useful byte.
        S_SKIP: begin
          if (emit_want) begin
            if (emit_go) begin
              lead_rem <= lead_rem - {3'b000, bus};
            end
          end else begin
            addr_offset     <= lead_rem[3:0];
            bytes_remaining <= useful_hold;
            state           <= S_IDLE;
          end
        end

        // A full beat left from a narrower width goes out before the byte.
        S_PRE: begin
          if (emit_go) begin
            if (beats_remaining == 5'd1) begin
              bytes_remaining <= 8'd0;
              state           <= S_IDLE;
            end else begin
              state <= S_H0;
            end
          end
        end

        // First digest word: (first ^ d) * MUL_FIRST.
        S_H0: begin
          mul_acc <= prod;
          state   <= S_H1;
        end
        S_H1: begin
          mul_acc <= acc_sum;
          state   <= S_H2;
        end
        S_H2: begin
          hash_first <= acc_sum;
          state      <= S_H3;
        end

        // Mix term for the second word, using the updated first word.
        S_H3: begin
          mix   <= hash_second + ((hash_first >> MIX_SHIFT) ^ {56'd0, in_data});
          state <= S_H4;
        end

        // Second digest word: mix * MUL_SECOND.
        S_H4: begin
          mul_acc <= prod;
          state   <= S_H5;
        end
        S_H5: begin
          mul_acc <= acc_sum;
          state   <= S_H6;
        end

        // Finish the digest and place the byte in its lane.
        S_H6: begin
          hash_second     <= acc_sum;
          beat_accum      <= beat_accum | ({56'd0, in_data} << {addr_offset[2:0], 3'b000});
          strobe_accum    <= strobe_accum | (8'd1 << addr_offset[2:0]);
          addr_offset     <= addr_offset + 4'd1;
          bytes_remaining <= bytes_remaining - 8'd1;
          state           <= S_POST;
        end

        // Send a filled beat, then close the burst after its last byte.
        S_POST: begin
          if (!emit_want || emit_go) begin
            if (bytes_remaining == 8'd0) begin
              if (off_after != 4'd0) begin
                state <= S_TAIL;
              end else begin
                state <= S_FLUSH;
              end
            end else begin
              if (beats_after == 5'd0) begin
                bytes_remaining <= 8'd0;
              end
              state <= S_IDLE;
            end
          end
        end

        // Partly filled final beat.
        S_TAIL: begin
          if (emit_go) begin
            state <= S_FLUSH;
          end
        end

        // Remaining beats of the burst with zero strobe.
        S_FLUSH: begin
          if (beats_remaining == 5'd0) begin
            bytes_remaining <= 8'd0;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An open burst that still expects bytes always owes at least one beat.
  `WBLP_ASSERT_SAME(a_bytes_need_beats, (state == S_IDLE) && (bytes_remaining != 8'd0), beats_remaining != 5'd0, "bytes pending with no beat left")

  // Strobe bits only stand below the next lane position.
  `WBLP_ASSERT_ALWAYS(a_strobe_below_offset, 8'(strobe_accum >> addr_offset) == 8'd0, "strobe set at or above lane position")

  // Sending the last beat of a burst leaves no beat owed.
  `WBLP_ASSERT_NEXT(a_last_closes_burst, emit_go && (beats_remaining == 5'd1), beats_remaining == 5'd0, "beats owed after last beat")

endmodule
